// ===== hdl/rational_arithmetic_unit_assert.svh =====
// Assertion macros for the rational arithmetic unit.
// Used by rational_arithmetic_unit; no other dependencies.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RAU_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rau assertion failed");
`define RAU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rau assertion failed");
`endif

// ===== hdl/rau_pkg.sv =====
// Package for the rational arithmetic unit: widths, action and status codes, states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
   localparam int WORD_BITS = 32;
   localparam int WIDE_BITS = 2 * WORD_BITS + 2;
   localparam int CNT_BITS  = $clog2(WIDE_BITS + 1);

   typedef enum logic [2:0] {
      ACT_NORM = 3'd0, ACT_ADD = 3'd1, ACT_SUB = 3'd2,
      ACT_MUL = 3'd3, ACT_DIV = 3'd4, ACT_CMP = 3'd5
   } action_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_GCD, S_DIVN, S_DIVD, S_CHECK, S_OUT
   } state_type;
endpackage
`default_nettype wire

// ===== hdl/rau_divider.sv =====
// Restoring divider for unsigned wide words, one quotient bit per cycle.
// Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rau_divider
   import rau_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  wire [WIDE_BITS-1:0]    dividend,
   input  wire [WIDE_BITS-1:0]    divisor,
   output logic                   busy,
   output logic [WIDE_BITS-1:0]   quotient,
   output logic [WIDE_BITS-1:0]   remainder
);
   logic [WIDE_BITS-1:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [WIDE_BITS:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      trial = {r_ff, q_ff[WIDE_BITS-1]} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor;
         cnt_in = CNT_BITS'(WIDE_BITS); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[WIDE_BITS]) begin
            r_in = trial[WIDE_BITS-1:0];
            q_in = {q_ff[WIDE_BITS-2:0], 1'b1};
         end else begin
            r_in = {r_ff[WIDE_BITS-2:0], q_ff[WIDE_BITS-1]};
            q_in = {q_ff[WIDE_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign busy      = busy_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;
endmodule
`default_nettype wire

// ===== hdl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit top level: sequencer, shared multiplier and Euclid gcd.
// Depends on rau_pkg, rau_divider and rational_arithmetic_unit_assert.svh.
// Usage:
//   A request (req_action, operands) is taken when req_valid and req_ready are high.
//   The block then works alone on it; req_ready is low until the result is taken.
//   One signed 33x33 multiplier is reused for the three cross products, in states
//   S_MUL1 to S_MUL3. A bit-serial divider serves the gcd remainders and the two
//   final exact divisions.
//   Compare and a zero divisor skip the gcd and go from S_COMB to the output; a zero
//   denominator or an unknown action reaches the output in the cycle after acceptance.
//   A new request is accepted only after the result is taken and the block is idle again.
//   The result is held on the rsp_ ports while rsp_valid is high and rsp_ready
//   low; a stalled receiver simply holds the block in its output state.
//   Reset (synchronous, active high) returns the block to idle, no result pending.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_arithmetic_unit_assert.svh"
module rational_arithmetic_unit
   import rau_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire [2:0]            req_action,
   input  wire signed [31:0]    req_a_num,
   input  wire signed [31:0]    req_a_den,
   input  wire signed [31:0]    req_b_num,
   input  wire [30:0]           req_b_den,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic signed [31:0]   rsp_res_num,
   output logic [30:0]          rsp_res_den,
   output logic                 rsp_is_less,
   output logic                 rsp_is_equal,
   output logic                 rsp_is_greater,
   output logic [1:0]           rsp_status
);
   state_type state_ff, state_in;
   logic [2:0] act_ff, act_in;
   logic signed [WORD_BITS:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic signed [WIDE_BITS-1:0] m1_ff, m1_in, m2_ff, m2_in, q_ff, q_in, p_ff, p_in;
   logic [WIDE_BITS-1:0] gx_ff, gx_in, gy_ff, gy_in, nq_ff, nq_in;
   logic neg_ff, neg_in;
   logic signed [31:0] rn_ff, rn_in;
   logic [30:0] rd_ff, rd_in;
   logic lt_ff, lt_in, eq_ff, eq_in, gt_ff, gt_in;
   logic [1:0] st_ff, st_in;
   logic signed [WORD_BITS:0] mul_a, mul_b;
   logic signed [2*WORD_BITS+1:0] mul_p;
   logic div_start;
   logic [WIDE_BITS-1:0] div_n, div_d, div_q, div_r;
   logic div_busy;
   logic signed [WIDE_BITS-1:0] diff;
   logic [WIDE_BITS-1:0] pmag;
   localparam logic [WIDE_BITS-1:0] NUM_MAX = WIDE_BITS'((64'd1 << (WORD_BITS-1)) - 1);

   assign mul_p = mul_a * mul_b;

   rau_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_n),
      .divisor(div_d), .busy(div_busy), .quotient(div_q), .remainder(div_r)
   );

   always_comb begin
      state_in = state_ff; act_in = act_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      m1_in = m1_ff; m2_in = m2_ff; q_in = q_ff; p_in = p_ff;
      gx_in = gx_ff; gy_in = gy_ff; nq_in = nq_ff; neg_in = neg_ff;
      rn_in = rn_ff; rd_in = rd_ff; lt_in = lt_ff; eq_in = eq_ff; gt_in = gt_ff;
      st_in = st_ff;
      mul_a = an_ff; mul_b = bd_ff;
      div_start = 1'b0; div_n = gx_ff; div_d = gy_ff;
      diff = m1_ff - m2_ff;
      pmag = p_ff[WIDE_BITS-1] ? WIDE_BITS'(-p_ff) : p_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               act_in = req_action;
               rn_in = '0; rd_in = 31'd1; lt_in = 1'b0; eq_in = 1'b0; gt_in = 1'b0;
               st_in = ST_OK;
               if (req_a_den[31]) begin
                  an_in = -{req_a_num[31], req_a_num};
                  ad_in = -{req_a_den[31], req_a_den};
               end else begin
                  an_in = {req_a_num[31], req_a_num};
                  ad_in = {req_a_den[31], req_a_den};
               end
               bn_in = {req_b_num[31], req_b_num};
               bd_in = {2'b00, req_b_den};
               if (req_action > 3'(ACT_CMP)) state_in = S_OUT;
               else if (req_a_den == 0 || (req_action != 3'(ACT_NORM) && req_b_den == 0)) begin
                  st_in = ST_ZERO; state_in = S_OUT;
               end else state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            case (act_ff)
               3'(ACT_NORM): begin mul_a = an_ff; mul_b = 33'sd1; end
               3'(ACT_MUL):  begin mul_a = an_ff; mul_b = bn_ff; end
               default:      begin mul_a = an_ff; mul_b = bd_ff; end
            endcase
            m1_in = WIDE_BITS'(mul_p);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            case (act_ff)
               3'(ACT_NORM): begin mul_a = 33'sd0; mul_b = 33'sd0; end
               3'(ACT_MUL):  begin mul_a = 33'sd0; mul_b = 33'sd0; end
               default:      begin mul_a = bn_ff; mul_b = ad_ff; end
            endcase
            m2_in = WIDE_BITS'(mul_p);
            state_in = S_MUL3;
         end
         S_MUL3: begin
            case (act_ff)
               3'(ACT_NORM): begin mul_a = ad_ff; mul_b = 33'sd1; end
               3'(ACT_DIV):  begin mul_a = ad_ff; mul_b = bn_ff; end
               default:      begin mul_a = ad_ff; mul_b = bd_ff; end
            endcase
            q_in = WIDE_BITS'(mul_p);
            state_in = S_COMB;
         end
         S_COMB: begin
            case (act_ff)
               3'(ACT_SUB): p_in = diff;
               3'(ACT_ADD): p_in = m1_ff + m2_ff;
               default:     p_in = m1_ff;
            endcase
            if (act_ff == 3'(ACT_CMP)) begin
               lt_in = diff[WIDE_BITS-1];
               eq_in = (diff == 0);
               gt_in = !diff[WIDE_BITS-1] && (diff != 0);
               state_in = S_OUT;
            end else if (q_ff == 0) begin
               st_in = ST_ZERO; state_in = S_OUT;
            end else begin
               state_in = S_GCD;
               gy_in = '0;
            end
         end
         S_GCD: begin
            if (gy_ff == '0 && !div_busy && nq_ff == '1) begin
               nq_in = '0;
            end
            if (!div_busy) begin
               if (gx_ff == '0 && gy_ff == '0) begin
                  if (q_ff[WIDE_BITS-1]) begin
                     p_in = -p_ff; q_in = -q_ff;
                  end
                  neg_in = 1'b0;
                  gx_in = q_ff[WIDE_BITS-1] ? WIDE_BITS'(-q_ff) : q_ff;
                  gy_in = (p_ff == 0) ? '0 :
                     (q_ff[WIDE_BITS-1] ? WIDE_BITS'(-p_ff) : p_ff);
                  gy_in = gy_in[WIDE_BITS-1] ? WIDE_BITS'(-gy_in) : gy_in;
                  if (p_ff == 0) begin
                     q_in = WIDE_BITS'(1); gx_in = WIDE_BITS'(1);
                  end
                  neg_in = 1'b1;
               end else if (gy_ff == '0) begin
                  state_in = S_DIVN; div_start = 1'b1;
                  div_n = pmag; div_d = gx_ff;
               end else if (neg_ff) begin
                  div_start = 1'b1; neg_in = 1'b0;
               end else begin
                  gx_in = gy_ff; gy_in = div_r; neg_in = 1'b1;
               end
            end
         end
         S_DIVN: begin
            div_n = q_ff; div_d = gx_ff;
            if (!div_busy) begin
               nq_in = div_q; div_start = 1'b1; state_in = S_DIVD;
            end
         end
         S_DIVD: begin
            if (!div_busy) begin
               q_in = div_q; state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (q_ff > NUM_MAX || (!p_ff[WIDE_BITS-1] && nq_ff > NUM_MAX) ||
                (p_ff[WIDE_BITS-1] && nq_ff > NUM_MAX + WIDE_BITS'(1))) begin
               st_in = ST_OVF;
            end else begin
               rn_in = p_ff[WIDE_BITS-1] ? 32'(-nq_ff) : 32'(nq_ff);
               rd_in = 31'(q_ff);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; gx_ff <= '0; gy_ff <= '0; neg_ff <= 1'b0; nq_ff <= '0;
      end else begin
         state_ff <= state_in; gx_ff <= (state_in == S_GCD && state_ff == S_COMB) ? '0 : gx_in;
         gy_ff <= gy_in; neg_ff <= neg_in; nq_ff <= nq_in;
      end
      act_ff <= act_in; an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      m1_ff <= m1_in; m2_ff <= m2_in; q_ff <= q_in; p_ff <= p_in;
      rn_ff <= rn_in; rd_ff <= rd_in; lt_ff <= lt_in; eq_ff <= eq_in; gt_ff <= gt_in;
      st_ff <= st_in;
   end

   assign rsp_valid      = (state_ff == S_OUT);
   assign rsp_res_num    = rn_ff;
   assign rsp_res_den    = rd_ff;
   assign rsp_is_less    = lt_ff;
   assign rsp_is_equal   = eq_ff;
   assign rsp_is_greater = gt_ff;
   assign rsp_status     = st_ff;

   `RAU_ASSERT_IMPL(a_ready_idle, req_ready, !rsp_valid)
   `RAU_ASSERT_IMPL(a_flags_onehot0, rsp_valid, $onehot0({rsp_is_less, rsp_is_equal, rsp_is_greater}))
   `RAU_ASSERT_NEXT(a_hold_stall, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_res_num))
   `RAU_ASSERT_IMPL(a_den_nonzero, rsp_valid, rsp_res_den != 31'd0)
endmodule
`default_nettype wire
